@@ sv/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define ASSERT_IMPLIES(label, clk, rst, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst) (cond) |-> (expr)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst) (cond) |=> (expr)) \
        else $error(msg);

`endif

@@ sv/mf3_pkg.sv @@
package mf3_pkg;

    localparam int MAX_WIDTH_DEF    = 1024;
    localparam int MAX_HEIGHT_DEF   = 1024;
    localparam int CHANNEL_BITS_DEF = 8;
    localparam int CFG_BITS         = 11;
    localparam int CFG_INDEX_BITS   = 2;
    localparam int DIM_RESET        = 1024;

    localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_HEIGHT = 2'd1;

    // which sides of the 3x3 neighbourhood lie inside the frame
    typedef struct packed {
        logic top;
        logic bottom;
        logic left_ok;
        logic right_ok;
    } nbr_mask_t;

    typedef struct packed {
        logic      emit;
        logic      last;
        nbr_mask_t mask;
    } s1_ctrl_t;

    function automatic int clamp_dim(int v, int hi);
        int r;
        r = v;
        if (r < 1)
        begin
            r = 1;
        end
        if (r > hi)
        begin
            r = hi;
        end
        return r;
    endfunction

endpackage

@@ sv/median_filter_3x3_rgb_top.sv @@
// 3x3 per-channel median filter for a raster-order RGB pixel stream.
// Input stream: one word per pixel, tdata = pixel (blue low, red high),
// tuser = 0 for a pixel, 1 for a flush tick. Flushes are ignored until
// every pixel of the frame is in; after that, flushes (or further pixels,
// whose data is dropped) push out the last results of the frame.
// Output stream: tdata = median pixel, tlast on the final pixel of a frame.
// Output pixel (r,c) is produced when the word W+1 positions later is taken,
// and appears once that word passes stages s1, s2, v3, v4 and v5.
// Throughput: one word per cycle unless the output stalls, set by the
// single line-store RAM port pair (one read at acceptance, one write from s1).
// Frame size comes from the config port (index 0 width, 1 height); a write
// restarts the frame; users write only while the filter is idle (unchecked).
// Reset: size 1024 x 1024 (clamped to the maximum), counters cleared; the
// line store is not cleared, off-frame rows never reach the output.
// A stalled output keeps its word; the five register stages still take
// input while any of them has room, then tready drops.
`include "assert_macros.svh"

module median_filter_3x3_rgb_top #(
    parameter int MAX_WIDTH    = mf3_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT   = mf3_pkg::MAX_HEIGHT_DEF,
    parameter int CHANNEL_BITS = mf3_pkg::CHANNEL_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // pixel_rgb
    input  logic [((3*CHANNEL_BITS+7)/8)*8-1:0] s_axis_tdata,
    // operation
    input  logic                               s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // median_rgb
    output logic [((3*CHANNEL_BITS+7)/8)*8-1:0] m_axis_tdata,
    output logic                               m_axis_tlast,
    input  logic                               cfg_we,
    input  logic [mf3_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [mf3_pkg::CFG_BITS-1:0]       cfg_data
);
    import mf3_pkg::*;

    localparam int PIX_BITS  = 3 * CHANNEL_BITS;
    localparam int DATA_BITS = ((PIX_BITS + 7) / 8) * 8;
    localparam int CW        = $clog2(MAX_WIDTH);
    localparam int WW        = $clog2(MAX_WIDTH + 1);
    localparam int HW        = $clog2(MAX_HEIGHT + 1);
    localparam int RW        = $clog2(MAX_HEIGHT + 2);
    localparam int ORW       = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    logic [WW-1:0]         eff_w_reg;
    logic [HW-1:0]         eff_h_reg;
    logic [CW-1:0]         in_col_reg;
    logic [RW-1:0]         in_row_reg;
    logic [CW-1:0]         out_col_reg;
    logic [ORW-1:0]        out_row_reg;
    logic                  fwd_reg;
    logic [2*PIX_BITS-1:0] fwd_data_reg;

    logic                  acc;
    logic                  in_frame;
    logic                  proc;
    logic                  emit;
    logic                  col_wrap;
    logic                  out_col_end;
    logic                  out_row_end;
    logic                  last;
    logic [PIX_BITS-1:0]   px_in;
    s1_ctrl_t              ld_ctrl;

    logic                  win_ready;
    logic                  ram_we;
    logic [CW-1:0]         ram_waddr;
    logic [2*PIX_BITS-1:0] ram_wdata;
    logic [2*PIX_BITS-1:0] ram_q;
    logic [2*PIX_BITS-1:0] line_word;
    logic                  nb_valid;
    logic                  nb_ready;
    logic [8:0][PIX_BITS-1:0] nb_pix;
    logic                  nb_last;
    logic [PIX_BITS-1:0]   out_pix;

    assign s_axis_tready = win_ready;
    assign acc      = s_axis_tvalid && s_axis_tready;
    assign in_frame = in_row_reg < RW'(eff_h_reg);
    assign proc     = acc && !(in_frame && s_axis_tuser);
    assign px_in    = in_frame ? s_axis_tdata[PIX_BITS-1:0] : '0;
    assign emit     = (in_row_reg >= RW'(2)) || (in_row_reg == RW'(1) && in_col_reg != '0);
    assign col_wrap    = (WW'(in_col_reg) + WW'(1)) == eff_w_reg;
    assign out_col_end = (WW'(out_col_reg) + WW'(1)) == eff_w_reg;
    assign out_row_end = (HW'(out_row_reg) + HW'(1)) == eff_h_reg;
    assign last        = out_row_end && out_col_end;

    always_comb
    begin
        ld_ctrl.emit           = emit;
        ld_ctrl.last           = last;
        ld_ctrl.mask.top       = out_row_reg != '0;
        ld_ctrl.mask.bottom    = !out_row_end;
        ld_ctrl.mask.left_ok   = out_col_reg != '0;
        ld_ctrl.mask.right_ok  = !out_col_end;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eff_w_reg   <= WW'(clamp_dim(DIM_RESET, MAX_WIDTH));
            eff_h_reg   <= HW'(clamp_dim(DIM_RESET, MAX_HEIGHT));
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            fwd_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_FRAME_WIDTH:
                    begin
                        eff_w_reg   <= WW'(clamp_dim(int'(cfg_data), MAX_WIDTH));
                        in_col_reg  <= '0;
                        in_row_reg  <= '0;
                        out_col_reg <= '0;
                        out_row_reg <= '0;
                    end
                    REG_FRAME_HEIGHT:
                    begin
                        eff_h_reg   <= HW'(clamp_dim(int'(cfg_data), MAX_HEIGHT));
                        in_col_reg  <= '0;
                        in_row_reg  <= '0;
                        out_col_reg <= '0;
                        out_row_reg <= '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            else if (proc)
            begin
                if (emit && last)
                begin
                    in_col_reg  <= '0;
                    in_row_reg  <= '0;
                    out_col_reg <= '0;
                    out_row_reg <= '0;
                end
                else
                begin
                    if (col_wrap)
                    begin
                        in_col_reg <= '0;
                        in_row_reg <= in_row_reg + RW'(1);
                    end
                    else
                    begin
                        in_col_reg <= in_col_reg + CW'(1);
                    end
                    if (emit)
                    begin
                        if (out_col_end)
                        begin
                            out_col_reg <= '0;
                            out_row_reg <= out_row_reg + ORW'(1);
                        end
                        else
                        begin
                            out_col_reg <= out_col_reg + CW'(1);
                        end
                    end
                end
            end
            if (proc)
            begin
                fwd_reg <= ram_we && (ram_waddr == in_col_reg);
            end
        end
    end

    // one-pixel rows read the column being written in the same cycle
    always_ff @(posedge clk)
    begin
        if (proc)
        begin
            fwd_data_reg <= ram_wdata;
        end
    end

    assign line_word = fwd_reg ? fwd_data_reg : ram_q;

    mf3_ram #(
        .WIDTH (2 * PIX_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (proc),
        .raddr (in_col_reg),
        .rdata (ram_q)
    );

    mf3_window #(
        .PIX_BITS (PIX_BITS),
        .COL_BITS (CW)
    ) u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (proc),
        .ld_ctrl   (ld_ctrl),
        .ld_px     (px_in),
        .ld_col    (in_col_reg),
        .ready     (win_ready),
        .line_word (line_word),
        .wr_en     (ram_we),
        .wr_col    (ram_waddr),
        .wr_data   (ram_wdata),
        .nb_valid  (nb_valid),
        .nb_ready  (nb_ready),
        .nb_pix    (nb_pix),
        .nb_last   (nb_last)
    );

    mf3_median #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_median (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (nb_valid),
        .in_ready  (nb_ready),
        .in_pix    (nb_pix),
        .in_last   (nb_last),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_pix   (out_pix),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = DATA_BITS'(out_pix);

    `ASSERT_IMPLIES(a_in_col_range, clk, rst_n, 1'b1, WW'(in_col_reg) < eff_w_reg, "input column beyond frame width")
    `ASSERT_IMPLIES(a_out_row_range, clk, rst_n, 1'b1, HW'(out_row_reg) < eff_h_reg, "output row beyond frame height")
    `ASSERT_NEXT(a_frame_restart, clk, rst_n, proc && emit && last && !cfg_we, in_row_reg == '0 && in_col_reg == '0 && out_col_reg == '0, "frame did not restart after its last pixel")

endmodule

@@ sv/mf3_ram.sv @@
module mf3_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/mf3_window.sv @@
module mf3_window #(
    parameter int PIX_BITS = 24,
    parameter int COL_BITS = 10
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     load,
    input  mf3_pkg::s1_ctrl_t        ld_ctrl,
    input  logic [PIX_BITS-1:0]      ld_px,
    input  logic [COL_BITS-1:0]      ld_col,
    output logic                     ready,
    input  logic [2*PIX_BITS-1:0]    line_word,
    output logic                     wr_en,
    output logic [COL_BITS-1:0]      wr_col,
    output logic [2*PIX_BITS-1:0]    wr_data,
    output logic                     nb_valid,
    input  logic                     nb_ready,
    output logic [8:0][PIX_BITS-1:0] nb_pix,
    output logic                     nb_last
);
    import mf3_pkg::*;

    logic                     s1_v_reg;
    s1_ctrl_t                 s1_ctrl_reg;
    logic [PIX_BITS-1:0]      s1_px_reg;
    logic [COL_BITS-1:0]      s1_col_reg;
    logic [2:0][PIX_BITS-1:0] col1_reg;
    logic [2:0][PIX_BITS-1:0] col2_reg;
    logic                     s2_v_reg;
    logic                     s2_v_next;
    logic [8:0][PIX_BITS-1:0] s2_pix_reg;
    logic                     s2_last_reg;

    logic                     s1_go;
    logic                     s2_free;
    logic [PIX_BITS-1:0]      up_px;
    logic [PIX_BITS-1:0]      mid_px;
    logic [8:0][PIX_BITS-1:0] raw;
    logic [8:0][PIX_BITS-1:0] padded;

    // line word: newer row in the upper half, the row before in the lower half
    assign up_px  = line_word[PIX_BITS-1:0];
    assign mid_px = line_word[2*PIX_BITS-1:PIX_BITS];

    assign s2_free = !s2_v_reg || nb_ready;
    assign s1_go   = s1_v_reg && (!s1_ctrl_reg.emit || s2_free);
    assign ready   = !s1_v_reg || s1_go;

    assign wr_en   = s1_go;
    assign wr_col  = s1_col_reg;
    assign wr_data = {s1_px_reg, mid_px};

    // left column, centre column, then the column arriving now
    always_comb
    begin
        raw[0] = col1_reg[0];
        raw[1] = col2_reg[0];
        raw[2] = up_px;
        raw[3] = col1_reg[1];
        raw[4] = col2_reg[1];
        raw[5] = mid_px;
        raw[6] = col1_reg[2];
        raw[7] = col2_reg[2];
        raw[8] = s1_px_reg;
    end

    // Off-frame places are padded so that the rank-4 element of all nine is
    // the upper median of the in-frame ones: 4 - n/2 zeros, the rest all ones.
    always_comb
    begin
        logic [2:0] rv;
        logic [2:0] cv;
        logic [8:0] ok;
        logic [3:0] nval;
        logic [3:0] zeros;
        logic [3:0] seen;
        rv = {s1_ctrl_reg.mask.bottom, 1'b1, s1_ctrl_reg.mask.top};
        cv = {s1_ctrl_reg.mask.right_ok, 1'b1, s1_ctrl_reg.mask.left_ok};
        nval = '0;
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                ok[r*3+c] = rv[r] & cv[c];
                nval = nval + 4'(rv[r] & cv[c]);
            end
        end
        zeros = 4'd4 - (nval >> 1);
        seen = '0;
        for (int i = 0; i < 9; i++)
        begin
            if (ok[i])
            begin
                padded[i] = raw[i];
            end
            else
            begin
                padded[i] = (seen < zeros) ? '0 : '1;
                seen = seen + 4'd1;
            end
        end
    end

    assign s2_v_next = (s1_go && s1_ctrl_reg.emit) ? 1'b1 : (nb_ready ? 1'b0 : s2_v_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
        end
        else
        begin
            if (ready)
            begin
                s1_v_reg <= load;
            end
            s2_v_reg <= s2_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready && load)
        begin
            s1_ctrl_reg <= ld_ctrl;
            s1_px_reg   <= ld_px;
            s1_col_reg  <= ld_col;
        end
        if (s1_go)
        begin
            col1_reg <= col2_reg;
            col2_reg <= {s1_px_reg, mid_px, up_px};
        end
        if (s1_go && s1_ctrl_reg.emit)
        begin
            s2_pix_reg  <= padded;
            s2_last_reg <= s1_ctrl_reg.last;
        end
    end

    assign nb_valid = s2_v_reg;
    assign nb_pix   = s2_pix_reg;
    assign nb_last  = s2_last_reg;

endmodule

@@ sv/mf3_median.sv @@
module mf3_median #(
    parameter int CHANNEL_BITS = 8
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [8:0][3*CHANNEL_BITS-1:0]       in_pix,
    input  logic                                 in_last,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [3*CHANNEL_BITS-1:0]            out_pix,
    output logic                                 out_last
);

    localparam int CB = CHANNEL_BITS;

    typedef logic [CB-1:0] ch_t;

    function automatic ch_t mn(ch_t a, ch_t b);
        return (a < b) ? a : b;
    endfunction

    function automatic ch_t mx(ch_t a, ch_t b);
        return (a < b) ? b : a;
    endfunction

    function automatic ch_t med3(ch_t a, ch_t b, ch_t c);
        return mx(mn(a, b), mn(mx(a, b), c));
    endfunction

    // per channel, per row: low, middle, high
    logic [2:0][2:0][2:0][CB-1:0] srt_reg;
    logic [2:0][2:0][2:0][CB-1:0] srt_next;
    logic [2:0][2:0][CB-1:0]      abc_reg;
    logic [2:0][2:0][CB-1:0]      abc_next;
    logic [3*CB-1:0]              res_reg;
    logic [3*CB-1:0]              res_next;
    logic                         l3_reg;
    logic                         l4_reg;
    logic                         l5_reg;
    logic                         v3_reg;
    logic                         v4_reg;
    logic                         v5_reg;
    logic                         free3;
    logic                         free4;
    logic                         free5;

    assign free5    = !v5_reg || out_ready;
    assign free4    = !v4_reg || free5;
    assign free3    = !v3_reg || free4;
    assign in_ready = free3;

    always_comb
    begin
        ch_t x0;
        ch_t x1;
        ch_t x2;
        for (int k = 0; k < 3; k++)
        begin
            for (int r = 0; r < 3; r++)
            begin
                x0 = in_pix[r*3][k*CB +: CB];
                x1 = in_pix[r*3+1][k*CB +: CB];
                x2 = in_pix[r*3+2][k*CB +: CB];
                srt_next[k][r][0] = mn(mn(x0, x1), x2);
                srt_next[k][r][1] = med3(x0, x1, x2);
                srt_next[k][r][2] = mx(mx(x0, x1), x2);
            end
        end
    end

    // max of lows, median of middles, min of highs
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            abc_next[k][0] = mx(mx(srt_reg[k][0][0], srt_reg[k][1][0]), srt_reg[k][2][0]);
            abc_next[k][1] = med3(srt_reg[k][0][1], srt_reg[k][1][1], srt_reg[k][2][1]);
            abc_next[k][2] = mn(mn(srt_reg[k][0][2], srt_reg[k][1][2]), srt_reg[k][2][2]);
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            res_next[k*CB +: CB] = med3(abc_reg[k][0], abc_reg[k][1], abc_reg[k][2]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (free3)
            begin
                v3_reg <= in_valid;
            end
            if (free4)
            begin
                v4_reg <= v3_reg;
            end
            if (free5)
            begin
                v5_reg <= v4_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (free3)
        begin
            srt_reg <= srt_next;
            l3_reg  <= in_last;
        end
        if (free4)
        begin
            abc_reg <= abc_next;
            l4_reg  <= l3_reg;
        end
        if (free5)
        begin
            res_reg <= res_next;
            l5_reg  <= l4_reg;
        end
    end

    assign out_valid = v5_reg;
    assign out_pix   = res_reg;
    assign out_last  = l5_reg;

endmodule
